[sv/bwed_pkg.sv]
// Shared constants and types for the banded wavefront edit distance block.
// No dependencies; every other file uses this package.
`default_nettype none
package bwed_pkg;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned MaxK   = 64;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned SymW     = 8;
  localparam int unsigned DistW    = 6;
  localparam int unsigned BandW    = 7;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 1;

  localparam logic [ApbAddrW-1:0] BandLimitAddr = '0;
  localparam logic [BandW-1:0]    BandLimitRst  = 7'd64;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_PAT = 2'd0,
    CMD_LOAD_TXT = 2'd1,
    CMD_RUN      = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EXT_ISSUE,
    ST_EXT_CMP,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            pat;
    logic            txt;
    logic [SymW-1:0] symbol;
  } load_req_t;

endpackage
`default_nettype wire

[sv/bwed_in_if.sv]
// Input channel: command and symbol beats with valid/ready.
// Depends on bwed_pkg for field widths.
`default_nettype none
interface bwed_in_if;
  logic                          valid;
  logic                          ready;
  logic [bwed_pkg::CmdW-1:0]     command;
  logic [bwed_pkg::SymW-1:0]     symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface
`default_nettype wire

[sv/bwed_out_if.sv]
// Result channel: distance and over-limit beats with valid/ready.
// Depends on bwed_pkg for field widths.
`default_nettype none
interface bwed_out_if;
  logic                          valid;
  logic                          ready;
  logic [bwed_pkg::DistW-1:0]    distance;
  logic                          over_limit;

  modport source (output valid, output distance, output over_limit, input ready);
  modport sink   (input valid, input distance, input over_limit, output ready);
endinterface
`default_nettype wire

[sv/bwed_symbol_store.sv]
// Pattern and text symbol memories with fill counters and a compare read port.
// Depends on bwed_pkg.
`default_nettype none
module bwed_symbol_store #(
  parameter int unsigned MAX_LEN = bwed_pkg::MaxLen
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bwed_pkg::load_req_t            ld_i,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]   pat_pos_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]   txt_pos_i,
  output logic      [$clog2(MAX_LEN+1)-1:0]   pat_len_o,
  output logic      [$clog2(MAX_LEN+1)-1:0]   txt_len_o,
  output logic                                match_o
);
  import bwed_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN+1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [SymW-1:0] pat_mem [MAX_LEN];
  logic [SymW-1:0] txt_mem [MAX_LEN];
  logic [SymW-1:0] pat_rd_q, txt_rd_q;
  logic [LW-1:0]   pat_len_q, txt_len_q;
  logic            pat_wr, txt_wr;

  assign pat_wr = ld_i.pat && (pat_len_q < LW'(MAX_LEN));
  assign txt_wr = ld_i.txt && (txt_len_q < LW'(MAX_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      txt_len_q <= '0;
    end else begin
      if (pat_wr) pat_len_q <= pat_len_q + 1'b1;
      if (txt_wr) txt_len_q <= txt_len_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_wr) pat_mem[pat_len_q[AW-1:0]] <= ld_i.symbol;
    if (rd_en_i) pat_rd_q <= pat_mem[pat_pos_i[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (txt_wr) txt_mem[txt_len_q[AW-1:0]] <= ld_i.symbol;
    if (rd_en_i) txt_rd_q <= txt_mem[txt_pos_i[AW-1:0]];
  end

  assign pat_len_o = pat_len_q;
  assign txt_len_o = txt_len_q;
  assign match_o   = (pat_rd_q == txt_rd_q);

endmodule
`default_nettype wire

[sv/banded_wavefront_edit_distance.sv]
// Banded wavefront edit distance: top level with APB band register and run sequencer.
// Depends on bwed_pkg, bwed_in_if, bwed_out_if, bwed_symbol_store.
// Sequencing: a run passes ST_READ, ST_CALC and ST_WRITE for each wavefront cell, with
// ST_EXT_ISSUE and ST_EXT_CMP per matched symbol and ST_EXT_ISSUE (plus ST_EXT_CMP if read)
// to close each extension, over scores 0 to the band limit (clamped to 1..MAX_K) minus 1;
// the result beat is registered in ST_DONE. Throughput: one load beat per cycle while idle;
// input stalls for the whole run, and a finished run waits until the previous result beat is taken.
// Reset: lengths cleared, band_limit 64; the memories are not cleared.
`default_nettype none
module banded_wavefront_edit_distance #(
  parameter int unsigned MAX_LEN = bwed_pkg::MaxLen,
  parameter int unsigned MAX_K   = bwed_pkg::MaxK
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  bwed_in_if.sink                                 in_i,
  bwed_out_if.source                              out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bwed_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [bwed_pkg::ApbDataW-1:0]      pwdata,
  output logic      [bwed_pkg::ApbDataW-1:0]      prdata,
  output logic                                    pready
);
  import bwed_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_LEN+1);
  localparam int unsigned KW  = $clog2(MAX_K+1);
  localparam int unsigned DW  = KW + 1;
  localparam int unsigned WW  = $clog2(MAX_LEN+MAX_K+2);
  localparam int unsigned SW  = ((WW > DW) ? WW : DW) + 2;
  localparam int unsigned IW  = $clog2(2*MAX_K);

  // band register
  logic [BandW-1:0] band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= BandLimitRst;
    end else if (psel && penable && pwrite && paddr == BandLimitAddr) begin
      band_q <= pwdata[BandW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == BandLimitAddr) ? ApbDataW'(band_q) : '0;

  // symbol stores
  state_e        state_q, state_d;
  load_req_t     ld_req;
  logic          in_acc;
  logic          ext_rd;
  logic [LW-1:0] ex_q, ey_q, pat_len, txt_len;
  logic          sym_match;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign ld_req.pat    = in_acc && (in_i.command == CMD_LOAD_PAT);
  assign ld_req.txt    = in_acc && (in_i.command == CMD_LOAD_TXT);
  assign ld_req.symbol = in_i.symbol;

  bwed_symbol_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (ld_req),
    .rd_en_i   (ext_rd),
    .pat_pos_i (ey_q),
    .txt_pos_i (ex_q),
    .pat_len_o (pat_len),
    .txt_len_o (txt_len),
    .match_o   (sym_match)
  );

  // run state
  logic        [KW-1:0] r_q, kk_q;
  logic signed [DW-1:0] d_q;
  logic        [WW-1:0] lo_q, mid_q, hi_q, c_q;
  logic        [WW-1:0] wf_mem [2**(IW+1)];
  logic        [WW-1:0] wf_rdata_q;
  logic        [IW:0]   wf_raddr, wf_waddr;
  logic                 wf_rd, wf_wr;
  logic        [DistW-1:0] res_dist_q, out_dist_q;
  logic                 res_over_q, out_over_q, out_valid_q;

  logic signed [SW-1:0] d_s, r_s, hi_s, mid_s, lo_s, up_s, left_s, down_s, c_s;
  logic signed [SW-1:0] ex_s, ey_s, m_s, n_s, top_s, fd_s, cq_s;
  logic                 hi_ok, ext_ok, pre_hit, post_hit, last_d, last_r;
  logic        [KW-1:0] kk_new;

  always_comb begin
    if (band_q == '0) begin
      kk_new = KW'(1);
    end else if (32'(band_q) > MAX_K) begin
      kk_new = KW'(MAX_K);
    end else begin
      kk_new = KW'(band_q);
    end
  end

  always_comb begin
    d_s   = SW'(d_q);
    r_s   = SW'(r_q);
    m_s   = SW'(pat_len);
    n_s   = SW'(txt_len);
    top_s = (m_s > n_s) ? m_s : n_s;
    fd_s  = n_s - m_s;
    mid_s = SW'(mid_q);
    lo_s  = SW'(lo_q);
    cq_s  = SW'(c_q);
    hi_ok = (r_q != '0) && (d_s + 1 <= r_s - 1) && (d_s + 1 >= 1 - r_s);
    hi_s  = hi_ok ? SW'(wf_rdata_q) : '0;
    up_s   = hi_s + ((d_s < 0) ? SW'(1) : SW'(0));
    left_s = mid_s + 1;
    down_s = lo_s + ((d_s > 0) ? SW'(1) : SW'(0));
    if (r_q == '0) begin
      c_s = '0;
    end else begin
      c_s = up_s;
      if (left_s > c_s) c_s = left_s;
      if (down_s > c_s) c_s = down_s;
    end
    ex_s     = (d_s >= 0) ? c_s : c_s + d_s;
    ey_s     = (d_s >= 0) ? c_s - d_s : c_s;
    ext_ok   = (ex_s >= 0) && (ey_s >= 0) && (ex_s < n_s) && (ey_s < m_s);
    pre_hit  = (d_s == fd_s) && (c_s >= top_s);
    post_hit = (d_s == fd_s) && (cq_s >= top_s);
    last_d   = (d_s == r_s);
    last_r   = (r_q + 1'b1 == kk_q);
  end

  assign wf_rd    = (state_q == ST_READ);
  assign wf_wr    = (state_q == ST_WRITE);
  assign wf_raddr = {~r_q[0], IW'(d_s + 1 + SW'(MAX_K))};
  assign wf_waddr = {r_q[0], IW'(d_s + SW'(MAX_K))};
  assign ext_rd   = (state_q == ST_EXT_ISSUE) && (ey_q < pat_len) && (ex_q < txt_len);

  always_ff @(posedge clk_i) begin
    if (wf_wr) wf_mem[wf_waddr] <= c_q;
    if (wf_rd) wf_rdata_q <= wf_mem[wf_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_acc && in_i.command == CMD_RUN) state_d = ST_READ;
      ST_READ:      state_d = ST_CALC;
      ST_CALC: begin
        if (pre_hit)     state_d = ST_DONE;
        else if (ext_ok) state_d = ST_EXT_ISSUE;
        else             state_d = ST_WRITE;
      end
      ST_EXT_ISSUE: state_d = ext_rd ? ST_EXT_CMP : ST_WRITE;
      ST_EXT_CMP:   state_d = sym_match ? ST_EXT_ISSUE : ST_WRITE;
      ST_WRITE: begin
        if (post_hit || (last_d && last_r)) state_d = ST_DONE;
        else                                 state_d = ST_READ;
      end
      ST_DONE:      if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_dist_q  <= '0;
      out_over_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
        out_dist_q  <= res_dist_q;
        out_over_q  <= res_over_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        r_q  <= '0;
        d_q  <= '0;
        lo_q <= '0;
        mid_q <= '0;
        kk_q <= kk_new;
      end
      ST_CALC: begin
        hi_q <= WW'(hi_s);
        c_q  <= WW'(c_s);
        ex_q <= LW'(ex_s);
        ey_q <= LW'(ey_s);
        if (pre_hit) begin
          res_dist_q <= DistW'(r_q);
          res_over_q <= 1'b0;
        end
      end
      ST_EXT_CMP: begin
        if (sym_match) begin
          c_q  <= c_q + 1'b1;
          ex_q <= ex_q + 1'b1;
          ey_q <= ey_q + 1'b1;
        end
      end
      ST_WRITE: begin
        if (post_hit) begin
          res_dist_q <= DistW'(r_q);
          res_over_q <= 1'b0;
        end else if (last_d) begin
          r_q   <= r_q + 1'b1;
          d_q   <= -DW'(r_q + 1'b1);
          lo_q  <= '0;
          mid_q <= '0;
          if (last_r) begin
            res_dist_q <= '0;
            res_over_q <= 1'b1;
          end
        end else begin
          d_q   <= d_q + 1'b1;
          lo_q  <= mid_q;
          mid_q <= hi_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.distance   = out_dist_q;
  assign out_o.over_limit = out_over_q;

endmodule
`default_nettype wire

[sv/bwed_checker.sv]
// Port-level checks for the banded wavefront edit distance block, with its bind.
// Depends on bwed_pkg and the top level's ports.
`default_nettype none
module bwed_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic [bwed_pkg::CmdW-1:0]     in_command_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [bwed_pkg::DistW-1:0]    out_distance_i,
  input wire logic                          out_over_limit_i
);
  import bwed_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_over_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_over_limit_i |-> out_distance_i == '0)
    else $error("over-limit beat with nonzero distance");

  a_run_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CMD_RUN |=> !in_ready_i)
    else $error("input not stalled after run beat");

  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result beat without a run in progress");

endmodule

bind banded_wavefront_edit_distance bwed_checker u_bwed_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_command_i     (in_i.command),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_distance_i   (out_o.distance),
  .out_over_limit_i (out_o.over_limit)
);
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for banded_wavefront_edit_distance: loads sequences, runs
// the distance search under several band settings and checks every result beat.
// Depends on bwed_pkg, bwed_in_if, bwed_out_if and the block's RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bwed_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int BandCells = 2 * MaxK + 1;
  localparam int CycleLimit = 50000000;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [SymW-1:0] sym;
  } beat_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             over_limit;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  bwed_in_if  sym_bus ();
  bwed_out_if dist_bus ();

  banded_wavefront_edit_distance DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sym_bus),
    .out_o   (dist_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  beat_t   pending_beats[$];
  result_t expected_dist[$];
  int      errors = 0;
  bit      no_gaps = 0;

  logic [SymW-1:0] pat_mem[MaxLen];
  logic [SymW-1:0] txt_mem[MaxLen];
  int pat_len = 0;
  int txt_len = 0;
  int band_reg = BandLimitRst;
  int ext_tab[MaxLen][BandCells];
  int wf_reach[MaxK][MaxK];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int ext_at(int y, int x);
    int off;
    off = x - y + MaxK;
    if (y < 0 || x < 0 || y >= pat_len || x >= txt_len) return 0;
    if (off < 0 || off >= BandCells) return 0;
    return ext_tab[y][off];
  endfunction

  function automatic int wf_prev(int d, int r);
    if (r < 0 || d > r || d < -r) return 0;
    if (d >= 0) return wf_reach[r - d][r];
    return wf_reach[r][r + d];
  endfunction

  function automatic void wf_put(int d, int r, int v);
    if (d >= 0) wf_reach[r - d][r] = v;
    else wf_reach[r][r + d] = v;
  endfunction

  function automatic result_t search_distance();
    result_t res;
    int kk, top, fd, w0, up, left, down, c, ex, ey, x;
    res = '{distance: '0, over_limit: 1'b1};
    kk = band_reg;
    if (kk < 1) kk = 1;
    if (kk > MaxK) kk = MaxK;
    for (int y = pat_len - 1; y >= 0; y--) begin
      for (int off = kk; off >= -kk; off--) begin
        x = y + off;
        if (x < 0 || x >= txt_len) continue;
        c = (pat_mem[y] == txt_mem[x]) ? 1 : 0;
        if (c != 0 && x + 1 < txt_len && y + 1 < pat_len) c += ext_tab[y + 1][off + MaxK];
        ext_tab[y][off + MaxK] = c;
      end
    end
    top = (pat_len > txt_len) ? pat_len : txt_len;
    fd = txt_len - pat_len;
    w0 = ext_at(0, 0);
    wf_reach[0][0] = w0;
    if (fd == 0 && w0 >= top) return '{distance: '0, over_limit: 1'b0};
    for (int r = 1; r < kk; r++) begin
      for (int d = -r; d <= r; d++) begin
        up = wf_prev(d + 1, r - 1);
        left = wf_prev(d, r - 1) + 1;
        down = wf_prev(d - 1, r - 1);
        if (d > 0) down += 1;
        else if (d < 0) up += 1;
        c = up;
        if (left > c) c = left;
        if (down > c) c = down;
        if (d == fd && c >= top) return '{distance: DistW'(r), over_limit: 1'b0};
        ex = (d >= 0) ? c : c + d;
        ey = (d >= 0) ? c - d : c;
        if (ex >= 0 && ey >= 0 && ex < txt_len && ey < pat_len) begin
          c += ext_at(ey, ex);
          wf_put(d, r, c);
          if (d == fd && c >= top) return '{distance: DistW'(r), over_limit: 1'b0};
        end else begin
          wf_put(d, r, c);
        end
      end
    end
    return res;
  endfunction

  function automatic void apply_beat(beat_t b);
    case (b.cmd)
      CMD_LOAD_PAT: begin
        if (pat_len < MaxLen) begin
          pat_mem[pat_len] = b.sym;
          pat_len++;
        end
      end
      CMD_LOAD_TXT: begin
        if (txt_len < MaxLen) begin
          txt_mem[txt_len] = b.sym;
          txt_len++;
        end
      end
      CMD_RUN: expected_dist.push_back(search_distance());
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_bus.valid   <= 1'b0;
      sym_bus.command <= '0;
      sym_bus.symbol  <= '0;
      gap_left = 0;
    end else begin
      if (sym_bus.valid && sym_bus.ready) apply_beat('{cmd: sym_bus.command, sym: sym_bus.symbol});
      if (sym_bus.valid && !sym_bus.ready) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        gap_left--;
        sym_bus.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_t nb;
        nb = pending_beats.pop_front();
        sym_bus.command <= nb.cmd;
        sym_bus.symbol  <= nb.sym;
        sym_bus.valid   <= 1'b1;
        gap_left = pick_gap();
      end else begin
        sym_bus.valid <= 1'b0;
      end
    end
  end

  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (dist_bus.valid && dist_bus.ready) begin
        if (expected_dist.size() == 0) begin
          $display("%0t: unexpected result distance=%0d over_limit=%0b", $time,
                   dist_bus.distance, dist_bus.over_limit);
          errors++;
        end else begin
          result_t want;
          want = expected_dist.pop_front();
          if (want.distance !== dist_bus.distance || want.over_limit !== dist_bus.over_limit) begin
            $display("%0t: mismatch expected distance=%0d over_limit=%0b, got distance=%0d over_limit=%0b",
                     $time, want.distance, want.over_limit, dist_bus.distance, dist_bus.over_limit);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        dist_bus.ready <= 1'b0;
      end else begin
        dist_bus.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic push_beat(logic [CmdW-1:0] cmd, logic [SymW-1:0] sym);
    pending_beats.push_back('{cmd: cmd, sym: sym});
  endtask

  task automatic wait_idle();
    while (pending_beats.size() > 0 || expected_dist.size() > 0 || sym_bus.valid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_band(logic [ApbDataW-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BandLimitAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    band_reg = int'(value & 32'h7F);
    @(posedge clk_i);
  endtask

  int items = 0;
  int chunk, sym_range, p;
  logic [SymW-1:0] base[$];

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_beat(CMD_RUN, 8'h00);
    push_beat(CmdUnused, 8'hA5);
    push_beat(CMD_LOAD_PAT, 8'h00);
    push_beat(CMD_LOAD_PAT, 8'hFF);
    push_beat(CMD_RUN, 8'hFF);
    push_beat(CMD_LOAD_TXT, 8'hFF);
    push_beat(CMD_LOAD_TXT, 8'h00);
    push_beat(CMD_RUN, 8'h5A);
    push_beat(CMD_LOAD_TXT, 8'h00);
    push_beat(CMD_RUN, 8'h00);
    write_band(32'd0);
    push_beat(CMD_RUN, 8'h00);
    push_beat(CMD_LOAD_PAT, 8'h00);
    push_beat(CMD_RUN, 8'h00);
    write_band(32'd127);
    push_beat(CMD_RUN, 8'h00);
    write_band(32'd1);
    push_beat(CMD_RUN, 8'h00);
    write_band(32'd64);
    push_beat(CMD_RUN, 8'h00);
    items = 19;

    while (items < 450) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 9);
      if (p < 2) write_band(p == 0 ? 32'd64 : 32'd1);
      else if (p < 6) write_band($urandom());
      else if (p < 8) write_band($urandom_range(1, 64));
      chunk = $urandom_range(3, 16);
      sym_range = ($urandom_range(0, 1) == 0) ? 3 : 255;
      base.delete();
      for (int i = 0; i < chunk; i++) base.push_back(SymW'($urandom_range(0, sym_range)));
      if ($urandom_range(0, 9) != 0) begin
        foreach (base[i]) push_beat(CMD_LOAD_PAT, base[i]);
        items += chunk;
      end
      foreach (base[i]) begin
        p = $urandom_range(0, 39);
        if (p == 0) continue;
        if (p == 1) begin
          push_beat(CMD_LOAD_TXT, SymW'($urandom()));
          items++;
        end
        push_beat(CMD_LOAD_TXT, (p == 2) ? SymW'($urandom()) : base[i]);
        items++;
        if ($urandom_range(0, 49) == 0) begin
          push_beat(CmdUnused, SymW'($urandom()));
          items++;
        end
      end
      push_beat(CMD_RUN, SymW'($urandom()));
      items++;
      if ($urandom_range(0, 7) == 0) begin
        push_beat(CMD_RUN, SymW'($urandom()));
        items++;
      end
    end

    write_band(32'd3);
    push_beat(CMD_RUN, 8'h00);

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[banded_wavefront_edit_distance.f]
sv/bwed_pkg.sv
sv/bwed_in_if.sv
sv/bwed_out_if.sv
sv/bwed_symbol_store.sv
sv/banded_wavefront_edit_distance.sv
sv/bwed_checker.sv
test/tb_top.sv
